@@ hdl/hcw_pkg.sv @@
package hcw_pkg;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_INTEGRAL = 2'd0,
    OP_TERM     = 2'd1,
    OP_ENTRY    = 2'd2,
    OP_EVAL     = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TERMS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES     = 3'd5;

  // Datapath widths.
  localparam int DIV_STEPS   = 14;  // term magnitude bits
  localparam int ADDR_FULL_W = 25;  // unclipped integral address
  localparam int SUM_W       = 40;  // up to 64 terms of 32 bits
  localparam int SCORE_W     = 48;

  typedef struct packed {
    logic [7:0] image_rows;
    logic [7:0] image_cols;
    logic [6:0] window_rows;
    logic [6:0] window_cols;
    logic [4:0] terms_per_entry;
    logic [9:0] entry_count;
  } hcw_cfg_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    op_t         op;
    logic        wr_ok;
    logic [15:0] addr;
    logic [31:0] integral_value;
    logic [13:0] term_value;
    logic [31:0] threshold;
    logic [31:0] weight;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        gate;
    logic [7:0]  cx;
    logic [7:0]  cy;
  } hcw_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENT,
    S_TRD,
    S_TCHK,
    S_DIV,
    S_ADDR,
    S_IRD,
    S_IACC,
    S_FEND,
    S_DONE
  } state_t;

endpackage

@@ hdl/hcw_if.sv @@
interface hcw_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [15:0]        address;
  logic [31:0]        integral_value;
  logic signed [13:0] term_value;
  logic signed [31:0] feature_threshold;
  logic signed [31:0] weight;
  logic [7:0]         pixel_col;
  logic [7:0]         pixel_row;
  logic               mask_bit;

  modport source (output valid, opcode, address, integral_value, term_value,
                  feature_threshold, weight, pixel_col, pixel_row, mask_bit,
                  input ready);
  modport sink (input valid, opcode, address, integral_value, term_value,
                feature_threshold, weight, pixel_col, pixel_row, mask_bit,
                output ready);
endinterface

interface hcw_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         out_col;
  logic [7:0]         out_row;
  logic               passed;
  logic signed [47:0] score;

  modport source (output valid, out_col, out_row, passed, score, input ready);
  modport sink (input valid, out_col, out_row, passed, score, output ready);
endinterface

interface hcw_cfg_if import hcw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/haar_cascade_window_eval_unit.sv @@
// Haar cascade window evaluator.
// Channels: in_ch takes load and evaluate beats, out_ch returns one beat
// per evaluate item (col, row, passed, Q16.16 score), cfg_ch writes the six
// geometry and loop registers and is always ready. Load beats write the
// integral image, the term table or an entry's threshold and weight and
// return nothing. Items run strictly in order, so a load that follows an
// evaluation does not disturb it.
// A two-beat queue parts the accepting front from the executing back, so
// inputs keep flowing while the back works. Load beats retire at one per
// cycle while no evaluation is running. For each stored term an evaluation
// runs the 14-step serial divide that splits the term into window column
// and row, the address multiply and one integral memory read; a zero slot
// ends a feature entry early, and rejected or border pixels skip the
// cascade and go straight to their result.
// Reset clears control and loads the register defaults; the stores are
// not cleared and must be written before use. A stalled receiver holds
// the result in the output register; the back then waits with the next
// result but the queue still takes input beats until it is full.
module haar_cascade_window_eval_unit import hcw_pkg::*; #(
  parameter int INTEGRAL_DEPTH = 65536,
  parameter int MAX_TERMS = 16,
  parameter int MAX_ENTRIES = 512
) (
  input  logic      clk,
  input  logic      rst,
  hcw_in_if.sink    in_ch,
  hcw_out_if.source out_ch,
  hcw_cfg_if.sink   cfg_ch
);

  hcw_cfg_t  cfg;
  hcw_item_t head;
  logic      head_valid;
  logic      pop;

  // Configuration registers; the port never stalls.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_rows      <= 8'd255;
      cfg.image_cols      <= 8'd255;
      cfg.window_rows     <= 7'd24;
      cfg.window_cols     <= 7'd24;
      cfg.terms_per_entry <= 5'd16;
      cfg.entry_count     <= 10'd1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_IMAGE_ROWS:  cfg.image_rows      <= cfg_ch.data[7:0];
        REG_IMAGE_COLS:  cfg.image_cols      <= cfg_ch.data[7:0];
        REG_WINDOW_ROWS: cfg.window_rows     <= cfg_ch.data[6:0];
        REG_WINDOW_COLS: cfg.window_cols     <= cfg_ch.data[6:0];
        REG_TERMS:       cfg.terms_per_entry <= cfg_ch.data[4:0];
        REG_ENTRIES:     cfg.entry_count     <= cfg_ch.data[9:0];
        default: begin
        end
      endcase
    end
  end

  // The front classifies each beat (border and mask test, store range
  // checks) and queues it.
  hcw_front #(
    .INTEGRAL_DEPTH (INTEGRAL_DEPTH),
    .MAX_TERMS      (MAX_TERMS),
    .MAX_ENTRIES    (MAX_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // The back owns the stores and walks the cascade for each evaluation.
  hcw_back #(
    .INTEGRAL_DEPTH (INTEGRAL_DEPTH),
    .MAX_TERMS      (MAX_TERMS),
    .MAX_ENTRIES    (MAX_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ hdl/hcw_ram.sv @@
module hcw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/hcw_front.sv @@
module hcw_front import hcw_pkg::*; #(
  parameter int INTEGRAL_DEPTH = 65536,
  parameter int MAX_TERMS = 16,
  parameter int MAX_ENTRIES = 512
) (
  input  logic      clk,
  input  logic      rst,
  hcw_in_if.sink    in_ch,
  input  hcw_cfg_t  cfg,
  output hcw_item_t head,
  output logic      head_valid,
  input  logic      pop
);

  hcw_item_t  item;
  hcw_item_t  slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic [5:0] x1;
  logic [5:0] y1;
  logic       col_ok;
  logic       row_ok;

  // Half window sizes; the window corner sits this far up and left.
  assign x1 = cfg.window_cols[6:1];
  assign y1 = cfg.window_rows[6:1];

  assign col_ok = (in_ch.pixel_col >= 8'(x1)) &&
                  ((10'(in_ch.pixel_col) + 10'(x1) + 10'd1) <= 10'(cfg.image_cols));
  assign row_ok = (in_ch.pixel_row >= 8'(y1)) &&
                  ((10'(in_ch.pixel_row) + 10'(y1) + 10'd1) <= 10'(cfg.image_rows));

  always_comb begin
    item.op             = op_t'(in_ch.opcode);
    item.addr           = in_ch.address;
    item.integral_value = in_ch.integral_value;
    item.term_value     = in_ch.term_value;
    item.threshold      = in_ch.feature_threshold;
    item.weight         = in_ch.weight;
    item.col            = in_ch.pixel_col;
    item.row            = in_ch.pixel_row;
    item.gate           = in_ch.mask_bit && col_ok && row_ok;
    item.cx             = in_ch.pixel_col - 8'(x1);
    item.cy             = in_ch.pixel_row - 8'(y1);
    unique case (op_t'(in_ch.opcode))
      OP_INTEGRAL: item.wr_ok = 32'(in_ch.address) < 32'(INTEGRAL_DEPTH);
      OP_TERM:     item.wr_ok = 32'(in_ch.address) < 32'(MAX_ENTRIES * MAX_TERMS);
      OP_ENTRY:    item.wr_ok = 32'(in_ch.address) < 32'(MAX_ENTRIES);
      OP_EVAL:     item.wr_ok = 1'b0;
      default:     item.wr_ok = 1'b0;
    endcase
  end

  assign in_ch.ready = (cnt != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign head        = slots[rp];
  assign head_valid  = (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= item;
    end
  end

endmodule

@@ hdl/hcw_back.sv @@
module hcw_back import hcw_pkg::*; #(
  parameter int INTEGRAL_DEPTH = 65536,
  parameter int MAX_TERMS = 16,
  parameter int MAX_ENTRIES = 512
) (
  input  logic      clk,
  input  logic      rst,
  input  hcw_cfg_t  cfg,
  input  hcw_item_t head,
  input  logic      head_valid,
  output logic      pop,
  hcw_out_if.source out_ch
);

  localparam int IAW    = $clog2(INTEGRAL_DEPTH);
  localparam int TDEPTH = MAX_ENTRIES * MAX_TERMS;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int EAW    = $clog2(MAX_ENTRIES);
  localparam int HW     = $clog2(MAX_ENTRIES + 1);
  localparam int FW     = $clog2(MAX_TERMS + 1);
  localparam int DCW    = $clog2(DIV_STEPS);

  state_t state, state_next;

  logic [FW-1:0]             nf_eff;
  logic [HW-1:0]             nh_eff;
  logic [8:0]                stride;
  logic [7:0]                wstride;

  logic [HW-1:0]             h;
  logic [TAW-1:0]            base;
  logic [FW-1:0]             f;
  logic signed [SCORE_W-1:0] score_acc;
  logic signed [SUM_W-1:0]   term_sum;
  logic signed [31:0]        thr_r;
  logic signed [31:0]        w_r;
  logic [13:0]               dvd;
  logic [7:0]                rem;
  logic [DCW-1:0]            dcnt;
  logic [IAW-1:0]            iaddr;
  logic                      iok;
  logic                      tneg;
  logic [7:0]                cx;
  logic [7:0]                cy;
  logic [7:0]                col;
  logic [7:0]                row;
  logic                      res_passed;
  logic signed [SCORE_W-1:0] res_score;
  logic                      out_full;

  logic                      int_we;
  logic                      term_we;
  logic                      tw_we;
  logic                      load_out;

  logic [31:0]               int_rdata;
  logic [13:0]               term_rdata;
  logic [63:0]               tw_rdata;

  logic signed [13:0]        t;
  logic [13:0]               tmag;
  logic signed [31:0]        w_cur;
  logic                      marker;
  logic                      h_last;
  logic                      fail;
  logic [8:0]                rem_sh;
  logic                      ge;
  logic [14:0]               sum_x;
  logic [ADDR_FULL_W-1:0]    ia_full;
  logic signed [SUM_W-1:0]   ival;

  // Effective loop bounds after saturation.
  assign nf_eff = (cfg.terms_per_entry == 5'd0) ? FW'(1) :
                  (32'(cfg.terms_per_entry) > 32'(MAX_TERMS)) ? FW'(MAX_TERMS) :
                  FW'(cfg.terms_per_entry);
  assign nh_eff = (32'(cfg.entry_count) > 32'(MAX_ENTRIES)) ? HW'(MAX_ENTRIES) :
                  HW'(cfg.entry_count);
  assign stride  = 9'(cfg.image_rows) + 9'd1;
  assign wstride = 8'(cfg.window_rows) + 8'd1;

  hcw_ram #(.WIDTH(32), .DEPTH(INTEGRAL_DEPTH)) u_int_ram (
    .clk   (clk),
    .we    (int_we),
    .waddr (IAW'(head.addr)),
    .wdata (head.integral_value),
    .raddr (iaddr),
    .rdata (int_rdata)
  );

  hcw_ram #(.WIDTH(14), .DEPTH(TDEPTH)) u_term_ram (
    .clk   (clk),
    .we    (term_we),
    .waddr (TAW'(head.addr)),
    .wdata (head.term_value),
    .raddr (base + TAW'(f)),
    .rdata (term_rdata)
  );

  hcw_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_tw_ram (
    .clk   (clk),
    .we    (tw_we),
    .waddr (EAW'(head.addr)),
    .wdata ({head.threshold, head.weight}),
    .raddr (h[EAW-1:0]),
    .rdata (tw_rdata)
  );

  // Term decode. The threshold and weight are fresh from memory on the
  // first slot of an entry and held in registers afterwards.
  assign t      = signed'(term_rdata);
  assign tmag   = t[13] ? 14'(-t) : 14'(t);
  assign w_cur  = (f == '0) ? signed'(tw_rdata[31:0]) : w_r;
  assign marker = (f == '0) && (t == 14'sd0);
  assign h_last = (HW'(h + HW'(1)) == nh_eff);
  assign fail   = score_acc < SCORE_W'(w_cur);

  // One restoring step of (|t|-1) / (wh+1).
  assign rem_sh = {rem, dvd[13]};
  assign ge     = rem_sh >= {1'b0, wstride};

  assign sum_x   = 15'(cx) + 15'(dvd);
  assign ia_full = ADDR_FULL_W'(sum_x) * ADDR_FULL_W'(stride) +
                   ADDR_FULL_W'(cy) + ADDR_FULL_W'(rem);
  assign ival    = iok ? SUM_W'(int_rdata) : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (head_valid && head.op == OP_EVAL) begin
          state_next = head.gate ? S_ENT : S_DONE;
        end
      end
      S_ENT:  state_next = (h == nh_eff) ? S_DONE : S_TRD;
      S_TRD:  state_next = S_TCHK;
      S_TCHK: begin
        if (marker) begin
          state_next = (fail || h_last) ? S_DONE : S_ENT;
        end else if (t == 14'sd0) begin
          state_next = S_FEND;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV:  state_next = (dcnt == DCW'(DIV_STEPS - 1)) ? S_ADDR : S_DIV;
      S_ADDR: state_next = S_IRD;
      S_IRD:  state_next = S_IACC;
      S_IACC: state_next = (FW'(f + FW'(1)) == nf_eff) ? S_FEND : S_TRD;
      S_FEND: state_next = S_ENT;
      S_DONE: state_next = out_full ? S_DONE : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    int_we   = 1'b0;
    term_we  = 1'b0;
    tw_we    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        pop     = head_valid;
        int_we  = head_valid && head.op == OP_INTEGRAL && head.wr_ok;
        term_we = head_valid && head.op == OP_TERM && head.wr_ok;
        tw_we   = head_valid && head.op == OP_ENTRY && head.wr_ok;
      end
      S_DONE: load_out = !out_full;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      h        <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_full <= 1'b1;
      end else if (out_ch.ready) begin
        out_full <= 1'b0;
      end
      unique case (state)
        S_IDLE: h <= '0;
        S_TCHK: begin
          if (marker && !fail && !h_last) begin
            h <= h + HW'(1);
          end
        end
        S_FEND: h <= h + HW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        base       <= '0;
        f          <= '0;
        score_acc  <= '0;
        term_sum   <= '0;
        cx         <= head.cx;
        cy         <= head.cy;
        col        <= head.col;
        row        <= head.row;
        res_passed <= 1'b0;
        res_score  <= '0;
      end
      S_ENT: begin
        if (h == nh_eff) begin
          res_passed <= 1'b1;
          res_score  <= score_acc;
        end
      end
      S_TRD: begin
      end
      S_TCHK: begin
        if (f == '0) begin
          thr_r <= signed'(tw_rdata[63:32]);
          w_r   <= signed'(tw_rdata[31:0]);
        end
        if (marker) begin
          if (fail) begin
            res_passed <= 1'b0;
            res_score  <= '0;
          end else if (h_last) begin
            res_passed <= 1'b1;
            res_score  <= score_acc - SCORE_W'(w_cur);
          end else begin
            score_acc <= '0;
            base      <= base + TAW'(MAX_TERMS);
          end
        end
        tneg <= t[13];
        dvd  <= tmag - 14'd1;
        rem  <= '0;
        dcnt <= '0;
      end
      S_DIV: begin
        dvd  <= {dvd[12:0], ge};
        rem  <= ge ? 8'(rem_sh - {1'b0, wstride}) : 8'(rem_sh);
        dcnt <= dcnt + DCW'(1);
      end
      S_ADDR: begin
        iaddr <= ia_full[IAW-1:0];
        iok   <= ia_full < ADDR_FULL_W'(INTEGRAL_DEPTH);
      end
      S_IRD: begin
      end
      S_IACC: begin
        term_sum <= tneg ? term_sum - ival : term_sum + ival;
        f        <= f + FW'(1);
      end
      S_FEND: begin
        score_acc <= (term_sum >= SUM_W'(thr_r)) ? score_acc + SCORE_W'(w_r)
                                                 : score_acc - SCORE_W'(w_r);
        term_sum  <= '0;
        f         <= '0;
        base      <= base + TAW'(MAX_TERMS);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.out_col <= col;
      out_ch.out_row <= row;
      out_ch.passed  <= res_passed;
      out_ch.score   <= res_score;
    end
  end

  assign out_ch.valid = out_full;

`ifndef SYNTHESIS
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from an empty queue");
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !out_full) else $error("result overwrote a waiting beat");
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRD) |-> (f < nf_eff)) else $error("term slot past limit");
  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_DONE) |-> (h <= nh_eff))
    else $error("entry index past limit");
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> (state == S_DIV || state == S_ADDR))
    else $error("divider left early");
`endif

endmodule
